@@ hdl/rbr_pkg.sv @@
// rbr_pkg: shared types and constants for the reorder buffer reassembly block
// no dependencies
package rbr_pkg;
   localparam int BUFFER_ENTRIES = 8;
   localparam int MAX_CHUNK_BYTES = 1024;
   localparam int IDX_W = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
   localparam int CNT_W = $clog2(BUFFER_ENTRIES + 1);

   localparam logic [1:0] KIND_DELIVER = 2'd0;
   localparam logic [1:0] KIND_ACK     = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   typedef struct packed {
      logic [31:0] offset;
      logic [10:0] length;
      logic        final_chunk;
      logic [15:0] payload_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] chunk_offset;
      logic [10:0] chunk_length;
      logic [15:0] chunk_tag;
      logic        stream_done;
      logic        last_of_run;
   } rsp_type;

   // classified command from front to back
   typedef struct packed {
      req_type     pkt;
      logic        in_order;
   } cmd_type;
endpackage

@@ hdl/reorder_buffer_reassembly_top.sv @@
// reorder_buffer_reassembly_top: top level of the byte offset reorder buffer
// depends on rbr_pkg, rbr_front, rbr_back
//
//   channel  | handshake        | payload
//   request  | start / busy     | req_data (rbr_pkg::req_type)
//   response | rsp_strobe       | rsp_data (rbr_pkg::rsp_type)
//
// an out-of-order or rejected item passes the front register, then the result register
// an in-order item passes both and then drains buffered entries, one per cycle
// the drain sequencer in the back part closes the run with an ack, after at most BUFFER_ENTRIES entries
// synchronous active-high reset clears expected offset, valid bits and count
// the receiver cannot stall; each result shows for exactly one cycle
module reorder_buffer_reassembly_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rbr_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output rbr_pkg::rsp_type  rsp_data
);
   import rbr_pkg::*;
   logic        cmd_valid, cmd_take, back_idle;
   cmd_type     cmd_data;
   logic [31:0] expected;

   // front: accept and classify against the expected offset
   rbr_front u_front (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .expected(expected), .back_idle(back_idle), .busy(busy),
      .cmd_valid(cmd_valid), .cmd_data(cmd_data), .cmd_take(cmd_take)
   );

   // back: store, drain and respond
   rbr_back u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_take(cmd_take), .expected(expected), .idle(back_idle),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

`ifndef SYNTH
   // a transfer into the back part always yields a result next cycle
   a_take_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> rsp_strobe) else $error("no result after command");
   // a delivery that is not the last result is followed by another result
   a_run_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last_of_run |=> rsp_strobe) else $error("run broken");
   // ack and reject always close a run
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.kind != KIND_DELIVER |-> rsp_data.last_of_run)
      else $error("ack not last");
`endif
endmodule

@@ hdl/rbr_front.sv @@
// rbr_front: accepts a request, saturates its length and marks it in order or not
// depends on rbr_pkg
module rbr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  rbr_pkg::req_type    req_data,
   input  logic [31:0]         expected,
   input  logic                back_idle,
   output logic                busy,
   output logic                cmd_valid,
   output rbr_pkg::cmd_type    cmd_data,
   input  logic                cmd_take
);
   import rbr_pkg::*;
   logic    full_ff, full_in;
   cmd_type cmd_ff, cmd_in;
   req_type sat;

   always_comb begin
      sat = req_data;
      if (req_data.length > 11'(MAX_CHUNK_BYTES)) sat.length = 11'(MAX_CHUNK_BYTES);
   end

   // one item at a time: the next depends on the expected offset left by this one
   assign busy = full_ff || !back_idle;
   assign cmd_valid = full_ff;
   assign cmd_data = cmd_ff;

   always_comb begin
      full_in = full_ff;
      cmd_in = cmd_ff;
      if (cmd_take) full_in = 1'b0;
      if (start && !busy) begin
         full_in = 1'b1;
         cmd_in.pkt = sat;
         cmd_in.in_order = (req_data.offset == expected);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      cmd_ff <= cmd_in;
   end
endmodule

@@ hdl/rbr_back.sv @@
// rbr_back: entry store, drain sequencer and result generation
// depends on rbr_pkg
module rbr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  rbr_pkg::cmd_type   cmd_data,
   output logic               cmd_take,
   output logic [31:0]        expected,
   output logic               idle,
   output logic               rsp_strobe,
   output rbr_pkg::rsp_type   rsp_data
);
   import rbr_pkg::*;
   typedef enum logic [1:0] {S_IDLE, S_DRAIN} state_type;

   state_type state_ff, state_in;
   logic [31:0] exp_ff, exp_in;
   logic [BUFFER_ENTRIES-1:0] vld_ff, vld_in;
   logic [31:0] eoff_ff [BUFFER_ENTRIES];
   logic [10:0] elen_ff [BUFFER_ENTRIES];
   logic [15:0] etag_ff [BUFFER_ENTRIES];
   logic        efin_ff [BUFFER_ENTRIES];
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   req_type pkt_ff, pkt_in;
   logic stb_ff, stb_in;
   rsp_type rsp_ff, rsp_in;
   logic wr_en;
   logic [IDX_W-1:0] wr_idx, hit_idx;
   logic hit, dup, free_found;

   assign cmd_take = cmd_valid && (state_ff == S_IDLE);
   assign expected = exp_ff;
   assign idle = (state_ff == S_IDLE);
   assign rsp_strobe = stb_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      hit = 1'b0; hit_idx = '0; dup = 1'b0; free_found = 1'b0; wr_idx = '0;
      for (int i = BUFFER_ENTRIES-1; i >= 0; i--) begin
         if (vld_ff[i] && eoff_ff[i] == exp_ff) begin hit = 1'b1; hit_idx = IDX_W'(i); end
         if (!vld_ff[i]) begin free_found = 1'b1; wr_idx = IDX_W'(i); end
         if (vld_ff[i] && eoff_ff[i] == cmd_data.pkt.offset) dup = 1'b1;
      end
   end

   always_comb begin
      logic [31:0] gap;
      state_in = state_ff; exp_in = exp_ff; vld_in = vld_ff; cnt_in = cnt_ff;
      pkt_in = pkt_ff; stb_in = 1'b0; rsp_in = rsp_ff; wr_en = 1'b0;
      gap = cmd_data.pkt.offset - exp_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd_take) begin
               pkt_in = cmd_data.pkt;
               stb_in = 1'b1;
               rsp_in.chunk_offset = cmd_data.pkt.offset;
               rsp_in.chunk_tag = cmd_data.pkt.payload_tag;
               rsp_in.last_of_run = 1'b1;
               rsp_in.chunk_length = '0;
               rsp_in.stream_done = 1'b0;
               if (cmd_data.in_order) begin
                  rsp_in.kind = KIND_DELIVER;
                  rsp_in.chunk_length = cmd_data.pkt.length;
                  rsp_in.stream_done = cmd_data.pkt.final_chunk;
                  rsp_in.last_of_run = 1'b0;
                  exp_in = exp_ff + 32'(cmd_data.pkt.length);
                  state_in = S_DRAIN;
               end else if (cnt_ff >= CNT_W'(BUFFER_ENTRIES)) begin
                  rsp_in.kind = KIND_REJECT;
               end else begin
                  rsp_in.kind = KIND_ACK;
                  if (!dup && !gap[31] && free_found) begin
                     wr_en = 1'b1;
                     vld_in[wr_idx] = 1'b1;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
            end
         end
         S_DRAIN: begin
            stb_in = 1'b1;
            if (hit) begin
               rsp_in.kind = KIND_DELIVER;
               rsp_in.chunk_offset = eoff_ff[hit_idx];
               rsp_in.chunk_length = elen_ff[hit_idx];
               rsp_in.chunk_tag = etag_ff[hit_idx];
               rsp_in.stream_done = efin_ff[hit_idx];
               rsp_in.last_of_run = 1'b0;
               exp_in = exp_ff + 32'(elen_ff[hit_idx]);
               vld_in[hit_idx] = 1'b0;
               if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
            end else begin
               rsp_in.kind = KIND_ACK;
               rsp_in.chunk_offset = pkt_ff.offset;
               rsp_in.chunk_length = '0;
               rsp_in.chunk_tag = pkt_ff.payload_tag;
               rsp_in.stream_done = 1'b0;
               rsp_in.last_of_run = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; exp_ff <= '0; vld_ff <= '0; cnt_ff <= '0; stb_ff <= 1'b0;
      end else begin
         state_ff <= state_in; exp_ff <= exp_in; vld_ff <= vld_in;
         cnt_ff <= cnt_in; stb_ff <= stb_in;
      end
      pkt_ff <= pkt_in;
      rsp_ff <= rsp_in;
      if (wr_en) begin
         eoff_ff[wr_idx] <= cmd_data.pkt.offset;
         elen_ff[wr_idx] <= cmd_data.pkt.length;
         etag_ff[wr_idx] <= cmd_data.pkt.payload_tag;
         efin_ff[wr_idx] <= cmd_data.pkt.final_chunk;
      end
   end
endmodule

@@ dv/rbr_checker.sv @@
`timescale 1ns / 1ps
// rbr_checker: watches both channels of the reorder buffer, predicts results, compares
// depends on rbr_pkg
module rbr_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  rbr_pkg::req_type  req_data,
   input  logic              rsp_strobe,
   input  rbr_pkg::rsp_type  rsp_data,
   output int                fail_count,
   output int                pending_results
);
   import rbr_pkg::*;

   logic [31:0] next_offset;
   logic        slot_used [BUFFER_ENTRIES];
   logic [31:0] slot_offset [BUFFER_ENTRIES];
   logic [10:0] slot_length [BUFFER_ENTRIES];
   logic [15:0] slot_tag [BUFFER_ENTRIES];
   logic        slot_final [BUFFER_ENTRIES];
   int          slot_count;
   rsp_type     expected_chunks[$];

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic rsp_type make_rsp(logic [1:0] k, logic [31:0] o, logic [10:0] l,
                                        logic [15:0] t, logic d);
      rsp_type r;
      r.kind = k; r.chunk_offset = o; r.chunk_length = l;
      r.chunk_tag = t; r.stream_done = d; r.last_of_run = 1'b0;
      return r;
   endfunction

   task automatic reassemble(input req_type pkt);
      logic [10:0] len;
      logic [31:0] gap;
      logic        found, dup;
      rsp_type     r;
      len = (pkt.length > MAX_CHUNK_BYTES) ? 11'(MAX_CHUNK_BYTES) : pkt.length;
      if (pkt.offset == next_offset) begin
         expected_chunks.push_back(make_rsp(KIND_DELIVER, pkt.offset, len,
                                            pkt.payload_tag, pkt.final_chunk));
         next_offset += len;
         found = 1'b1;
         // drain buffered entries that continue the run, lowest slot first
         while (found) begin
            found = 1'b0;
            for (int i = 0; i < BUFFER_ENTRIES; i++) begin
               if (!found && slot_used[i] && slot_offset[i] == next_offset) begin
                  expected_chunks.push_back(make_rsp(KIND_DELIVER, slot_offset[i],
                     slot_length[i], slot_tag[i], slot_final[i]));
                  next_offset += slot_length[i];
                  slot_used[i] = 1'b0;
                  if (slot_count > 0) slot_count--;
                  found = 1'b1;
               end
            end
         end
         r = make_rsp(KIND_ACK, pkt.offset, '0, pkt.payload_tag, 1'b0);
      end else if (slot_count >= BUFFER_ENTRIES) begin
         r = make_rsp(KIND_REJECT, pkt.offset, '0, pkt.payload_tag, 1'b0);
      end else begin
         gap = pkt.offset - next_offset;
         dup = 1'b0;
         for (int i = 0; i < BUFFER_ENTRIES; i++)
            if (slot_used[i] && slot_offset[i] == pkt.offset) dup = 1'b1;
         if (!dup && !gap[31]) begin
            found = 1'b0;
            for (int i = 0; i < BUFFER_ENTRIES; i++) begin
               if (!found && !slot_used[i]) begin
                  slot_used[i] = 1'b1; slot_offset[i] = pkt.offset;
                  slot_length[i] = len; slot_tag[i] = pkt.payload_tag;
                  slot_final[i] = pkt.final_chunk;
                  slot_count++;
                  found = 1'b1;
               end
            end
         end
         r = make_rsp(KIND_ACK, pkt.offset, '0, pkt.payload_tag, 1'b0);
      end
      r.last_of_run = 1'b1;
      expected_chunks.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         next_offset = '0;
         slot_count = 0;
         for (int i = 0; i < BUFFER_ENTRIES; i++) slot_used[i] = 1'b0;
         expected_chunks.delete();
      end else begin
         if (start && !busy) reassemble(req_data);
         if (rsp_strobe) begin
            if (expected_chunks.size() == 0) begin
               report_mismatch($sformatf("unexpected result %p", rsp_data));
            end else begin
               e = expected_chunks.pop_front();
               if (rsp_data.kind !== e.kind)
                  report_mismatch($sformatf("kind %0d want %0d", rsp_data.kind, e.kind));
               if (rsp_data.chunk_offset !== e.chunk_offset)
                  report_mismatch($sformatf("offset %h want %h",
                                            rsp_data.chunk_offset, e.chunk_offset));
               if (rsp_data.chunk_length !== e.chunk_length)
                  report_mismatch($sformatf("length %0d want %0d",
                                            rsp_data.chunk_length, e.chunk_length));
               if (rsp_data.chunk_tag !== e.chunk_tag)
                  report_mismatch($sformatf("tag %h want %h", rsp_data.chunk_tag,
                                            e.chunk_tag));
               if (rsp_data.stream_done !== e.stream_done)
                  report_mismatch($sformatf("stream_done %b want %b",
                                            rsp_data.stream_done, e.stream_done));
               if (rsp_data.last_of_run !== e.last_of_run)
                  report_mismatch($sformatf("last_of_run %b want %b",
                                            rsp_data.last_of_run, e.last_of_run));
            end
         end
      end
      pending_results = expected_chunks.size();
   end
endmodule

@@ dv/reorder_buffer_reassembly_top_tb.sv @@
`timescale 1ns / 1ps
// reorder_buffer_reassembly_top_tb: stimulus and verdict for the reorder buffer
// depends on rbr_pkg, reorder_buffer_reassembly_top, rbr_checker
module reorder_buffer_reassembly_top_tb;
   import rbr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = BUFFER_ENTRIES + 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_results;
   int      idle_cycles = 0;

   // stream position the generator believes is next in order
   logic [31:0] gen_offset = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   reorder_buffer_reassembly_top uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   rbr_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending_results(pending_results)
   );

   // watchdog: counts cycles in which no transfer happens on either channel
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // one transfer: hold start from a falling edge until a rising edge sees busy low
   task automatic send_packet(input logic [31:0] off, input logic [10:0] len,
                              input logic fin, input logic [15:0] tag);
      req_data <= '{offset: off, length: len, final_chunk: fin, payload_tag: tag};
      start <= 1'b1;
      // busy only moves at rising edges, so its value here holds until the next one
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic pause_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   // random length, mostly small, sometimes zero, max or oversized
   function automatic logic [10:0] pick_length();
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'(MAX_CHUNK_BYTES);
         2:       return 11'($urandom_range(MAX_CHUNK_BYTES + 1, 2047));
         default: return 11'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [10:0] sat_len(input logic [10:0] l);
      return (l > MAX_CHUNK_BYTES) ? 11'(MAX_CHUNK_BYTES) : l;
   endfunction

   // a run of consecutive chunks sent in shuffled order, so buffered entries drain
   task automatic send_shuffled_run(input int count);
      logic [31:0] offs[$];
      logic [10:0] lens[$];
      logic [31:0] o;
      logic [10:0] l;
      int          j;
      o = gen_offset;
      for (int i = 0; i < count; i++) begin
         l = pick_length();
         offs.push_back(o); lens.push_back(l);
         o += sat_len(l);
      end
      gen_offset = o;
      for (int i = count - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         o = offs[i]; offs[i] = offs[j]; offs[j] = o;
         l = lens[i]; lens[i] = lens[j]; lens[j] = l;
      end
      for (int i = 0; i < count; i++) begin
         send_packet(offs[i], lens[i],
                     (i == count - 1) ? 1'($urandom_range(0, 1)) : 1'b0,
                     16'($urandom));
         // a duplicate now and then
         if ($urandom_range(0, 7) == 0)
            send_packet(offs[i], lens[i], 1'b0, 16'($urandom));
         if ($urandom_range(0, 3) == 0) pause_cycles($urandom_range(1, 12));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: in-order, zero length, oversized, old, duplicate
      send_packet(32'd0, 11'd100, 1'b0, 16'h0000);
      send_packet(32'd100, 11'd0, 1'b1, 16'hFFFF);
      send_packet(32'd100, 11'd2047, 1'b0, 16'h1234);     // saturates to max
      send_packet(32'd0, 11'd10, 1'b0, 16'hAAAA);          // old
      send_packet(32'hFFFF_FFFF, 11'd10, 1'b1, 16'h5555);  // far behind, old
      // fill every slot out of order, then one more: buffer full rejects
      for (int i = 1; i <= BUFFER_ENTRIES; i++)
         send_packet(32'd1124 + 32'(i) * 32'd16, 11'd16, i == BUFFER_ENTRIES, 16'(i));
      send_packet(32'd1124 + 32'd16, 11'd16, 1'b0, 16'hBEEF);  // full beats duplicate
      send_packet(32'd9000, 11'd5, 1'b0, 16'hBEEF);            // full reject
      send_packet(32'd1124, 11'd16, 1'b0, 16'h7777);           // drains all slots
      send_packet(32'd1124 + 32'd16 * 32'd9 + 32'd50, 11'd1, 1'b0, 16'h0001);
      send_packet(32'd1124 + 32'd16 * 32'd9 + 32'd50, 11'd1, 1'b1, 16'h0002); // dup
      gen_offset = 32'd1124 + 32'd16 * 32'd9;
      send_packet(gen_offset, 11'd50, 1'b0, 16'h0003);    // drains the single entry
      gen_offset += 32'd51;

      // random: shuffled runs, with noise, bursts and gaps
      for (int n = 0; n < 60; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: random offset anywhere, sometimes followed by an in-order zero-length packet
            send_packet($urandom, pick_length(), 1'($urandom_range(0, 1)), 16'($urandom));
            if ($urandom_range(0, 3) == 0) begin
               send_packet(gen_offset, 11'd0, 1'b0, 16'($urandom));
            end
         end
         if (n == 30) begin
            start <= 1'b0;
            @(negedge clock);
            while (pending_results != 0) @(negedge clock);
            // wait until every predicted result has been seen
         end
         send_shuffled_run($urandom_range(1, BUFFER_ENTRIES + 1));
         if ($urandom_range(0, 1)) pause_cycles($urandom_range(1, 20));
      end
      start <= 1'b0;

      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
